@@ sv/grid_transposition_decoder_unit_macros.svh @@
// assertion macros for the grid transposition decoder checker
// no dependencies; included by the checker file only
`ifndef GRID_TRANSPOSITION_DECODER_UNIT_MACROS_SVH
`define GRID_TRANSPOSITION_DECODER_UNIT_MACROS_SVH

// same-cycle implication under the active-low reset
`define GTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under the active-low reset
`define GTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/gtd_pkg.sv @@
// shared types, codes and the character decode for the grid transposition decoder
// no dependencies
package gtd_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_EOR   = 2'd1;
	localparam logic [1:0] CMD_DRAIN = 2'd2;
	localparam logic [1:0] CMD_NEW   = 2'd3;

	localparam logic [7:0] CH_UNDERSCORE = 8'd95;
	localparam logic [7:0] CH_BACKSLASH  = 8'd92;
	localparam logic [7:0] CH_SPACE      = 8'd32;
	localparam logic [7:0] CH_NEWLINE    = 8'd10;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] in_char;
	} gtd_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} gtd_out_t;

	// read tag that travels alongside the grid read
	typedef struct packed {
		logic valid;
		logic last;
	} gtd_meta_t;

	function automatic logic [7:0] gtd_decode(input logic [7:0] ch);
		logic [7:0] r;
		if (ch == CH_UNDERSCORE) begin
			r = CH_SPACE;
		end else if (ch == CH_BACKSLASH) begin
			r = CH_NEWLINE;
		end else begin
			r = ch;
		end
		return r;
	endfunction

endpackage

@@ sv/grid_transposition_decoder_unit.sv @@
// top level of the grid transposition decoder
// depends on gtd_pkg, gtd_ctrl, gtd_ram and gtd_out
//
// usage
//  - input channel: item = {cmd, in_char}; a transaction is taken at a rising
//    edge with start high and busy low. busy stays low, so one command a cycle
//  - cmd load writes in_char into the current row, end of row closes it (the
//    first row fixes the width), start new message clears the counters but not
//    the grid contents, request next output reads one cell
//  - drain order: last column to first, inside a column last row to first;
//    trailing underscores in that order are dropped, last marks the final char
//  - result channel: result = {out_char, last} with strobe high for exactly one
//    cycle; the receiver cannot stall, so results must be taken as they come
//  - path: a drain request passes the command register, the grid read and the
//    result register on its way to the result strobe
//  - throughput: one command per cycle, set by the single grid memory port
//    pair (one write per load, one read per drain)
//  - reset: arst_n clears all counters and puts the block in loading state;
//    the grid memory is not cleared and needs no sweep
module grid_transposition_decoder_unit #(
	parameter int MAX_ROWS = gtd_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gtd_pkg::MAX_COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gtd_pkg::gtd_in_t  item,
	output gtd_pkg::gtd_out_t result,
	output logic              strobe
);
	import gtd_pkg::*;

	// grid address is {row, column}, each field as wide as its index needs
	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AW  = RIW + CIW;

	logic          accept;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	gtd_meta_t     meta;

	// every command completes in one pass, nothing ever holds the channel off
	assign busy   = 1'b0;
	assign accept = start && !busy;

	gtd_ctrl #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.AW      (AW)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.item  (item),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.meta  (meta)
	);

	// grid store, one byte per cell
	gtd_ram #(
		.AW(AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// underscore to space, backslash to newline, then register the result
	gtd_out u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.meta  (meta),
		.rdata (rdata),
		.result(result),
		.strobe(strobe)
	);
endmodule

@@ sv/gtd_ram.sv @@
// grid store: one write port, one registered read port
// depends on nothing but its address width parameter
module gtd_ram #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	localparam int DEPTH = 2 ** AW;

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ sv/gtd_ctrl.sv @@
// command register, load/drain sequencer and grid addressing
// depends on gtd_pkg
module gtd_ctrl #(
	parameter int MAX_ROWS = gtd_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gtd_pkg::MAX_COLS_DEF,
	parameter int AW       = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  gtd_pkg::gtd_in_t   item,
	output logic               we,
	output logic [AW-1:0]      waddr,
	output logic [7:0]         wdata,
	output logic               re,
	output logic [AW-1:0]      raddr,
	output gtd_pkg::gtd_meta_t meta
);
	import gtd_pkg::*;

	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLS + 1);
	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam logic [RCW-1:0] ROWS_C = RCW'(MAX_ROWS);
	localparam logic [CCW-1:0] COLS_C = CCW'(MAX_COLS);

	typedef enum logic [1:0] {
		PH_LOAD,
		PH_DRAIN,
		PH_DONE
	} phase_t;

	gtd_in_t   item_s1;
	logic      valid_s1;
	gtd_meta_t meta_s2;

	phase_t         phase_q, phase_d;
	logic [RCW-1:0] rows_q, rows_d, krow_q, krow_d, rrow_q, rrow_d;
	logic [CCW-1:0] width_q, width_d, wcol_q, wcol_d, kcol_q, kcol_d, rcol_q, rcol_d;
	logic           kf_q, kf_d;
	gtd_meta_t      meta_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		logic           do_end;
		logic [RCW-1:0] rc_e, rc_use, prow;
		logic [CCW-1:0] w_e, limit, pcol;
		logic           empty, go, is_last;
		phase_d  = phase_q;
		rows_d   = rows_q;
		width_d  = width_q;
		wcol_d   = wcol_q;
		kcol_d   = kcol_q;
		krow_d   = krow_q;
		kf_d     = kf_q;
		rcol_d   = rcol_q;
		rrow_d   = rrow_q;
		meta_d   = '0;
		we       = 1'b0;
		waddr    = {rows_q[RIW-1:0], wcol_q[CIW-1:0]};
		wdata    = item_s1.in_char;
		re       = 1'b0;
		go       = 1'b0;
		is_last  = 1'b0;
		prow     = rrow_q;
		pcol     = rcol_q;
		rc_use   = rows_q;
		// implied end of a partly loaded row at the first drain request
		do_end   = (wcol_q != '0) && (rows_q < ROWS_C);
		rc_e     = do_end ? rows_q + RCW'(1) : rows_q;
		w_e      = (do_end && rows_q == '0) ? wcol_q : width_q;
		limit    = (rows_q == '0) ? COLS_C : width_q;
		empty    = !kf_q || rc_e == '0 || w_e == '0 || kcol_q >= w_e || krow_q >= rc_e;
		if (valid_s1) begin
			unique case (item_s1.cmd)
				CMD_LOAD: begin
					if (phase_q == PH_LOAD && rows_q < ROWS_C && wcol_q < COLS_C) begin
						we = 1'b1;
						if (item_s1.in_char != CH_UNDERSCORE && wcol_q < limit &&
								(!kf_q || wcol_q < kcol_q)) begin
							kf_d   = 1'b1;
							kcol_d = wcol_q;
							krow_d = rows_q;
						end
						wcol_d = wcol_q + CCW'(1);
					end
				end
				CMD_EOR: begin
					if (phase_q == PH_LOAD && rows_q < ROWS_C) begin
						if (rows_q == '0) begin
							width_d = wcol_q;
						end
						rows_d = rows_q + RCW'(1);
						wcol_d = '0;
					end
				end
				CMD_NEW: begin
					phase_d = PH_LOAD;
					rows_d  = '0;
					width_d = '0;
					wcol_d  = '0;
					kcol_d  = '1;
					krow_d  = '0;
					kf_d    = 1'b0;
					rcol_d  = '0;
					rrow_d  = '0;
				end
				CMD_DRAIN: begin
					if (phase_q == PH_LOAD) begin
						rows_d  = rc_e;
						width_d = w_e;
						if (do_end) begin
							wcol_d = '0;
						end
						if (empty) begin
							phase_d = PH_DONE;
						end else begin
							go     = 1'b1;
							prow   = rc_e - RCW'(1);
							pcol   = w_e - CCW'(1);
							rc_use = rc_e;
						end
					end else if (phase_q == PH_DRAIN) begin
						go = 1'b1;
					end
					if (go) begin
						re          = 1'b1;
						is_last     = (prow == krow_q) && (pcol == kcol_q);
						meta_d.valid = 1'b1;
						meta_d.last  = is_last;
						phase_d     = PH_DRAIN;
						if (is_last) begin
							phase_d = PH_DONE;
						end else if (prow == '0) begin
							if (pcol == '0) begin
								phase_d = PH_DONE;
							end else begin
								rcol_d = pcol - CCW'(1);
								rrow_d = rc_use - RCW'(1);
							end
						end else begin
							rrow_d = prow - RCW'(1);
							rcol_d = pcol;
						end
					end
				end
				default: begin
				end
			endcase
		end
		raddr = {prow[RIW-1:0], pcol[CIW-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOAD;
			rows_q  <= '0;
			width_q <= '0;
			wcol_q  <= '0;
			kcol_q  <= '1;
			krow_q  <= '0;
			kf_q    <= 1'b0;
			rcol_q  <= '0;
			rrow_q  <= '0;
			meta_s2 <= '0;
		end else begin
			phase_q <= phase_d;
			rows_q  <= rows_d;
			width_q <= width_d;
			wcol_q  <= wcol_d;
			kcol_q  <= kcol_d;
			krow_q  <= krow_d;
			kf_q    <= kf_d;
			rcol_q  <= rcol_d;
			rrow_q  <= rrow_d;
			meta_s2 <= meta_d;
		end
	end

	assign meta = meta_s2;
endmodule

@@ sv/gtd_out.sv @@
// character decode and result register
// depends on gtd_pkg
module gtd_out (
	input  logic               clk,
	input  logic               arst_n,
	input  gtd_pkg::gtd_meta_t meta,
	input  logic [7:0]         rdata,
	output gtd_pkg::gtd_out_t  result,
	output logic               strobe
);
	import gtd_pkg::*;

	gtd_out_t result_q;
	logic     strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= meta.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (meta.valid) begin
			result_q.out_char <= gtd_decode(rdata);
			result_q.last     <= meta.last;
		end
	end

	assign result = result_q;
	assign strobe = strobe_q;
endmodule

@@ sv/gtd_chk.sv @@
// port-level checker for the grid transposition decoder, bound to the top level
// depends on gtd_pkg and grid_transposition_decoder_unit_macros.svh
`include "grid_transposition_decoder_unit_macros.svh"

module gtd_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input gtd_pkg::gtd_in_t  item,
	input gtd_pkg::gtd_out_t result,
	input logic              strobe
);
	import gtd_pkg::*;

	// the block takes a command every cycle
	`GTD_ASSERT_NOW(a_never_busy, clk, arst_n, 1'b1, !busy, "busy raised")

	// a result only ever answers a drain transaction taken earlier
	`GTD_ASSERT_NOW(a_result_from_drain, clk, arst_n, strobe,
		$past(start && !busy && item.cmd == CMD_DRAIN, 3), "result without drain request")

	// after the final character no result can follow in the next cycle
	`GTD_ASSERT_NEXT(a_quiet_after_last, clk, arst_n, strobe && result.last, !strobe,
		"result right after last")
endmodule

bind grid_transposition_decoder_unit gtd_chk u_chk (.*);
